@@ rtl/sha1d_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest unit package
// Word types, sequencer states, control groups and SHA-1 constants shared by
// the digest unit and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1d_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Round function group: rounds 0-19, 20-39, 40-59 and 60-79.
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY_A,
    PH_MAJORITY,
    PH_PARITY_B
  } phase_t;

  typedef struct packed {
    logic       byte_en;
    logic       word_en;
    logic       round_en;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  typedef struct packed {
    logic   round_en;
    logic   update_en;
    logic   iv_load;
    phase_t phase;
  } core_ctrl_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] ROUND_LAST   = 7'd79;
  localparam logic [6:0] ROUND_PH1    = 7'd20;
  localparam logic [6:0] ROUND_PH2    = 7'd40;
  localparam logic [6:0] ROUND_PH3    = 7'd60;
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] FILL_LEN_POS = 6'd56;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

endpackage

`default_nettype wire

@@ rtl/sha1_digest_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest unit
// Byte-serial SHA-1 engine with an iterative round core and a registered
// digest output.
// ----------------------------------------------------------------------------
// The unit takes the message one byte per input word and returns the 160-bit
// digest as one output word after the word marked last_byte. The
// sixty-fourth byte of a block starts the compression, which runs one round
// per cycle through a single shared round core: 80 rounds and then an update
// that adds the result into the chaining words, with in_stall high
// throughout. Finishing a message writes the padding one byte per cycle,
// paused by any compression, through the same byte path (the 0x80 mark,
// zeros and the 64-bit big-endian bit length), so the last word brings
// between 9 and 72 padding bytes and one or two compressions before the
// digest is loaded. The digest sits in an output register; the unit accepts
// new bytes while it waits there, and only holds off a further digest until
// it is taken. After a digest the unit is ready for a new message.
`default_nettype none

module sha1_digest_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sha1d_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sha1d_pkg::out_word_t      out_word
);

  sha1d_pkg::state_t      state_r, state_nxt;
  logic [5:0]             fill_r;
  logic [63:0]            len_r;
  logic [6:0]             rnd_r;
  logic                   fin_r;
  logic                   mark_r;
  logic                   lenph_r;
  logic                   out_valid_r;
  sha1d_pkg::out_word_t   out_word_r;

  sha1d_pkg::sched_ctrl_t sched_ctrl;
  sha1d_pkg::core_ctrl_t  core_ctrl;
  sha1d_pkg::phase_t      round_phase;
  sha1d_pkg::out_word_t   digest;
  logic [31:0]            sched_w;

  logic                   accept;
  logic                   data_en;
  logic                   block_full;
  logic                   len_now;
  logic                   out_load;
  logic [63:0]            len_shift;

  // Length bytes go out most significant first, at buffer positions 56 to 63.
  assign len_shift = len_r << {fill_r[2:0], 3'b000};
  assign len_now   = lenph_r || (fill_r == sha1d_pkg::FILL_LEN_POS);

  // Output logic of the sequencer.
  always_comb begin
    accept              = 1'b0;
    data_en             = 1'b0;
    out_load            = 1'b0;
    in_stall            = 1'b1;
    sched_ctrl.byte_en  = 1'b0;
    sched_ctrl.round_en = 1'b0;
    sched_ctrl.byte_val = in_word.data_byte;
    core_ctrl.round_en  = 1'b0;
    core_ctrl.update_en = 1'b0;
    core_ctrl.iv_load   = 1'b0;
    core_ctrl.phase     = round_phase;
    case (state_r)
      sha1d_pkg::ST_IDLE: begin
        in_stall           = 1'b0;
        accept             = in_valid;
        data_en            = in_valid && !in_word.no_data;
        sched_ctrl.byte_en = data_en;
      end
      sha1d_pkg::ST_PAD: begin
        sched_ctrl.byte_en = 1'b1;
        if (mark_r) begin
          sched_ctrl.byte_val = sha1d_pkg::PAD_MARK;
        end else if (len_now) begin
          sched_ctrl.byte_val = len_shift[63:56];
        end else begin
          sched_ctrl.byte_val = 8'h00;
        end
      end
      sha1d_pkg::ST_ROUND: begin
        sched_ctrl.round_en = 1'b1;
        core_ctrl.round_en  = 1'b1;
      end
      sha1d_pkg::ST_UPDATE: begin
        core_ctrl.update_en = 1'b1;
      end
      sha1d_pkg::ST_DONE: begin
        out_load          = !out_valid_r || !out_stall;
        core_ctrl.iv_load = out_load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    sched_ctrl.word_en = sched_ctrl.byte_en && (fill_r[1:0] == 2'b11);
    block_full         = sched_ctrl.byte_en && (fill_r == sha1d_pkg::FILL_LAST);
  end

  always_comb begin
    if (rnd_r < sha1d_pkg::ROUND_PH1) begin
      round_phase = sha1d_pkg::PH_CHOOSE;
    end else if (rnd_r < sha1d_pkg::ROUND_PH2) begin
      round_phase = sha1d_pkg::PH_PARITY_A;
    end else if (rnd_r < sha1d_pkg::ROUND_PH3) begin
      round_phase = sha1d_pkg::PH_MAJORITY;
    end else begin
      round_phase = sha1d_pkg::PH_PARITY_B;
    end
  end

  // Next-state logic. After a compression the sequencer returns to taking
  // bytes, resumes padding, or presents the digest once the length is in.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1d_pkg::ST_IDLE: begin
        if (accept) begin
          if (block_full) begin
            state_nxt = sha1d_pkg::ST_ROUND;
          end else if (in_word.last_byte) begin
            state_nxt = sha1d_pkg::ST_PAD;
          end
        end
      end
      sha1d_pkg::ST_PAD: begin
        if (block_full) begin
          state_nxt = sha1d_pkg::ST_ROUND;
        end
      end
      sha1d_pkg::ST_ROUND: begin
        if (rnd_r == sha1d_pkg::ROUND_LAST) begin
          state_nxt = sha1d_pkg::ST_UPDATE;
        end
      end
      sha1d_pkg::ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = sha1d_pkg::ST_IDLE;
        end else if (lenph_r) begin
          state_nxt = sha1d_pkg::ST_DONE;
        end else begin
          state_nxt = sha1d_pkg::ST_PAD;
        end
      end
      sha1d_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = sha1d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha1d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1d_pkg::ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      lenph_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sched_ctrl.byte_en) begin
        fill_r <= fill_r + 6'd1;
      end
      // The bit length counts message bytes only, never padding.
      if (out_load) begin
        len_r <= '0;
      end else if (data_en) begin
        len_r <= len_r + sha1d_pkg::BITS_PER_BYTE;
      end
      if (state_r == sha1d_pkg::ST_ROUND) begin
        rnd_r <= rnd_r + 7'd1;
      end else begin
        rnd_r <= '0;
      end
      if (accept && in_word.last_byte) begin
        fin_r  <= 1'b1;
        mark_r <= 1'b1;
      end else if (out_load) begin
        fin_r <= 1'b0;
      end else if (state_r == sha1d_pkg::ST_PAD) begin
        mark_r <= 1'b0;
      end
      if (out_load) begin
        lenph_r <= 1'b0;
      end else if (state_r == sha1d_pkg::ST_PAD && !mark_r
                   && fill_r == sha1d_pkg::FILL_LEN_POS) begin
        lenph_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= digest;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  sha1d_msg_sched u_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .sched_w (sched_w)
  );

  sha1d_round_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (core_ctrl),
    .sched_w (sched_w),
    .digest  (digest)
  );

  // A compression only ever starts on a completely filled block.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == sha1d_pkg::ST_ROUND) |-> fill_r == 6'd0)
    else $error("compression started on a partial block");

  // The eightieth round is always followed by the chaining update.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1d_pkg::ST_ROUND && rnd_r == sha1d_pkg::ROUND_LAST)
      |=> state_r == sha1d_pkg::ST_UPDATE)
    else $error("round count and sequencer out of step");

  // A digest is only presented after the length block was compressed.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1d_pkg::ST_DONE |-> (lenph_r && fin_r && fill_r == 6'd0))
    else $error("digest stage reached without a finished padding");

  // A new digest word appears only out of the digest stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(state_r) == sha1d_pkg::ST_DONE)
    else $error("digest word raised outside the digest stage");

endmodule

`default_nettype wire

@@ rtl/sha1d_msg_sched.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Packs bytes into big-endian words and keeps the sixteen-word schedule
// window as a shift line that also produces the expanded words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1d_msg_sched (
  input  wire logic                  clk,
  input  wire sha1d_pkg::sched_ctrl_t ctrl,
  output logic [31:0]                sched_w
);

  logic [23:0] asm_r;
  logic [23:0] asm_nxt;
  logic [31:0] win_r   [16];
  logic [31:0] win_in;
  logic [31:0] expand_x;

  // Window entry i holds W[t+i]; the new entry is W[t+16].
  assign expand_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign win_in   = ctrl.word_en ? {asm_r, ctrl.byte_val} : {expand_x[30:0], expand_x[31]};
  assign asm_nxt  = {asm_r[15:0], ctrl.byte_val};
  assign sched_w  = win_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.byte_en) begin
      asm_r <= asm_nxt;
    end
    if (ctrl.word_en || ctrl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= win_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1d_round_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 round core
// Holds the chaining words and the working variables and applies one SHA-1
// round per cycle, then folds the working variables into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1d_round_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha1d_pkg::core_ctrl_t ctrl,
  input  wire logic [31:0]          sched_w,
  output sha1d_pkg::out_word_t      digest
);

  logic [31:0] h0_r, h1_r, h2_r, h3_r, h4_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_nxt;
  logic [31:0] s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt;

  always_comb begin
    case (ctrl.phase)
      sha1d_pkg::PH_CHOOSE: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = sha1d_pkg::K_R0;
      end
      sha1d_pkg::PH_PARITY_A: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1d_pkg::K_R1;
      end
      sha1d_pkg::PH_MAJORITY: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = sha1d_pkg::K_R2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1d_pkg::K_R3;
      end
    endcase
  end

  assign t_nxt  = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + sched_w;
  assign s0_nxt = h0_r + a_r;
  assign s1_nxt = h1_r + b_r;
  assign s2_nxt = h2_r + c_r;
  assign s3_nxt = h3_r + d_r;
  assign s4_nxt = h4_r + e_r;

  // The working variables equal the chaining words whenever no block is in
  // flight, so a block starts without a separate load step.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.iv_load) begin
      h0_r <= sha1d_pkg::IV0;
      h1_r <= sha1d_pkg::IV1;
      h2_r <= sha1d_pkg::IV2;
      h3_r <= sha1d_pkg::IV3;
      h4_r <= sha1d_pkg::IV4;
      a_r  <= sha1d_pkg::IV0;
      b_r  <= sha1d_pkg::IV1;
      c_r  <= sha1d_pkg::IV2;
      d_r  <= sha1d_pkg::IV3;
      e_r  <= sha1d_pkg::IV4;
    end else if (ctrl.update_en) begin
      h0_r <= s0_nxt;
      h1_r <= s1_nxt;
      h2_r <= s2_nxt;
      h3_r <= s3_nxt;
      h4_r <= s4_nxt;
      a_r  <= s0_nxt;
      b_r  <= s1_nxt;
      c_r  <= s2_nxt;
      d_r  <= s3_nxt;
      e_r  <= s4_nxt;
    end else if (ctrl.round_en) begin
      a_r <= t_nxt;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign digest.digest_word_0 = h0_r;
  assign digest.digest_word_1 = h1_r;
  assign digest.digest_word_2 = h2_r;
  assign digest.digest_word_3 = h3_r;
  assign digest.digest_word_4 = h4_r;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest unit testbench
// Feeds byte-serial messages into the digest unit under random idling on both
// channels and checks every digest against a SHA-1 predictor kept in the
// bench itself.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  // One hold-off of the result channel that is long enough for the digest
  // register to fill and for the unit to stall its input.
  localparam int HOLD_CYCLES  = 1500;
  // A message finish takes at most 72 padding bytes, two compressions and the
  // digest load, so this covers any late digest.
  localparam int DRAIN_CYCLES = 400;
  // Several times the slowest legal run, when every word ends a message under
  // the longest idling on both sides.
  localparam int LIMIT_CYCLES = 2000000;
  // Keeps a badly broken run from flooding the log.
  localparam int REPORT_CAP   = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sha1d_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  sha1d_pkg::out_word_t out_word;

  sha1_digest_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Predictor state: chaining words, block buffer, fill count and the
  // running message length in bits.
  logic [31:0] hash_h [5];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [63:0] msg_bits;

  // Digests that have been caused by accepted words and not yet seen.
  sha1d_pkg::out_word_t digest_q [$];

  int          fail_count;
  int          report_count;
  int          data_items;

  // Traffic shaping shared between the stimulus and the receiver.
  bit          quiet;
  bit          hold_req;
  int          tx_gap_pct;

  // --------------------------------------------------------------------------
  // SHA-1 predictor.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void hash_restart();
    hash_h[0]  = sha1d_pkg::IV0;
    hash_h[1]  = sha1d_pkg::IV1;
    hash_h[2]  = sha1d_pkg::IV2;
    hash_h[3]  = sha1d_pkg::IV3;
    hash_h[4]  = sha1d_pkg::IV4;
    block_fill = '0;
    msg_bits   = '0;
  endfunction

  // Runs the 80 rounds over msg_block and folds the result into hash_h.
  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int t = 0; t < 16; t++) begin
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        wt = rotl(sched[(t-3) & 15] ^ sched[(t-8) & 15] ^ sched[(t-14) & 15]
                  ^ sched[t & 15], 1);
        sched[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1d_pkg::K_R0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1d_pkg::K_R1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1d_pkg::K_R2;
      end else begin
        f = b ^ c ^ d;
        k = sha1d_pkg::K_R3;
      end
      tmp = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  // Appends the 0x80 mark, zeros and the big-endian bit length, spilling
  // into a second block when fewer than nine bytes are left.
  function automatic void pad_and_close();
    int pos;
    pos = int'(block_fill);
    msg_block[pos] = sha1d_pkg::PAD_MARK;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) begin
      msg_block[56+i] = msg_bits[63-8*i -: 8];
    end
    compress_block();
  endfunction

  // Takes one accepted input word and queues the digest that it causes.
  function automatic void absorb_word(sha1d_pkg::in_word_t w);
    sha1d_pkg::out_word_t dg;
    if (!w.no_data) begin
      msg_block[block_fill] = w.data_byte;
      block_fill = block_fill + 6'd1;
      msg_bits   = msg_bits + 64'd8;
      if (block_fill == '0) begin
        compress_block();
      end
    end
    if (w.last_byte) begin
      pad_and_close();
      dg.digest_word_0 = hash_h[0];
      dg.digest_word_1 = hash_h[1];
      dg.digest_word_2 = hash_h[2];
      dg.digest_word_3 = hash_h[3];
      dg.digest_word_4 = hash_h[4];
      digest_q = {digest_q, dg};
      hash_restart();
    end
  endfunction

  // Compares one accepted digest, field by field, with the oldest one due.
  function automatic void check_digest(sha1d_pkg::out_word_t got);
    sha1d_pkg::out_word_t exp;
    logic [31:0]          exp_f [5];
    logic [31:0]          got_f [5];
    if (digest_q.size() == 0) begin
      fail_count++;
      if (report_count < REPORT_CAP) begin
        report_count++;
        $display("%0t: unexpected digest, expected none, actual %h", $time, got);
      end
      return;
    end
    exp = digest_q.pop_front();
    exp_f = '{exp.digest_word_0, exp.digest_word_1, exp.digest_word_2,
              exp.digest_word_3, exp.digest_word_4};
    got_f = '{got.digest_word_0, got.digest_word_1, got.digest_word_2,
              got.digest_word_3, got.digest_word_4};
    for (int i = 0; i < 5; i++) begin
      if (got_f[i] !== exp_f[i]) begin
        fail_count++;
        if (report_count < REPORT_CAP) begin
          report_count++;
          $display("%0t: digest_word_%0d mismatch, expected %h, actual %h",
                   $time, i, exp_f[i], got_f[i]);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, and the monitor that watches both channels at the rising edge.
  // The digest check runs before the new word is absorbed; a digest leaving
  // at the same edge always belongs to an earlier message.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_digest(out_word);
      end
      if (in_valid && !in_stall) begin
        absorb_word(in_word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It stalls in random bursts whose density changes from one
  // window to the next, so there are calm stretches as well as busy ones. On
  // request it holds off for one long stretch, counted here, while the
  // sender keeps offering words.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    int window;
    int rx_pct;
    out_stall = 1'b0;
    window    = 0;
    rx_pct    = 0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        window = 256;
        case ($urandom_range(0, 2))
          0:       rx_pct = 0;
          1:       rx_pct = 8;
          default: rx_pct = 30;
        endcase
      end
      window--;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. A word is put on the bus at a falling edge, optionally after an
  // idle burst, and held until the rising edge that accepts it. in_stall is
  // read right after the edge, before the unit's registers update.
  // --------------------------------------------------------------------------
  task automatic send_word(sha1d_pkg::in_word_t w);
    int gap;
    gap = 0;
    if (!quiet && tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 18);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends one message of len data bytes. It ends either with last on the
  // final byte or with a separate empty last word; ignored words without
  // last are sprinkled in as noise.
  task automatic send_message(int len);
    sha1d_pkg::in_word_t w;
    int                  fill_mode;
    bit                  tail_empty;
    fill_mode  = $urandom_range(0, 9);
    tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        w.data_byte = 8'($urandom);
        w.last_byte = 1'b0;
        w.no_data   = 1'b1;
        send_word(w);
      end
      case (fill_mode)
        0:       w.data_byte = 8'h00;
        1:       w.data_byte = 8'hFF;
        default: w.data_byte = 8'($urandom);
      endcase
      w.no_data   = 1'b0;
      w.last_byte = !tail_empty && (i == len - 1);
      send_word(w);
      data_items++;
    end
    if (tail_empty) begin
      w.data_byte = 8'($urandom);
      w.last_byte = 1'b1;
      w.no_data   = 1'b1;
      send_word(w);
      data_items++;
    end
  endtask

  // Mostly short messages, with a good share sitting right at the padding
  // and block boundaries, and a few long ones that span several blocks.
  function automatic int pick_length();
    int sel;
    int edges [10];
    edges = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      return $urandom_range(0, 12);
    end else if (sel < 85) begin
      return edges[$urandom_range(0, 9)];
    end
    return $urandom_range(13, 190);
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return 10;
      default: return 35;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // An empty last word with nothing absorbed gives the empty-message digest;
  // two in a row check that the unit re-initializes after each digest.
  task automatic test_empty_message();
    sha1d_pkg::in_word_t w;
    w.data_byte = 8'hA5;
    w.last_byte = 1'b1;
    w.no_data   = 1'b1;
    send_word(w);
    w.data_byte = 8'h5A;
    send_word(w);
  endtask

  // One-byte messages at both ends of the byte range and at 0x80, finished by
  // the data word itself.
  task automatic test_single_byte_extremes();
    sha1d_pkg::in_word_t w;
    w.no_data   = 1'b0;
    w.last_byte = 1'b1;
    w.data_byte = 8'h00;
    send_word(w);
    w.data_byte = 8'hFF;
    send_word(w);
    w.data_byte = 8'h80;
    send_word(w);
  endtask

  // The classic three-byte message.
  task automatic test_abc_vector();
    sha1d_pkg::in_word_t w;
    w.no_data   = 1'b0;
    w.last_byte = 1'b0;
    w.data_byte = 8'h61;
    send_word(w);
    w.data_byte = 8'h62;
    send_word(w);
    w.data_byte = 8'h63;
    w.last_byte = 1'b1;
    send_word(w);
  endtask

  // Words without data and without last must change nothing, both at the
  // start of a message and in its middle. An empty last word after data
  // finishes the message held so far, and a one-byte message follows.
  task automatic test_ignored_and_trailing_finish();
    sha1d_pkg::in_word_t w;
    w.data_byte = 8'hFF;
    w.last_byte = 1'b0;
    w.no_data   = 1'b1;
    send_word(w);
    w.data_byte = 8'h3C;
    w.no_data   = 1'b0;
    send_word(w);
    w.data_byte = 8'h00;
    w.no_data   = 1'b1;
    send_word(w);
    w.data_byte = 8'hC3;
    w.no_data   = 1'b0;
    send_word(w);
    w.data_byte = 8'h7E;
    w.last_byte = 1'b1;
    w.no_data   = 1'b1;
    send_word(w);
    w.data_byte = 8'h01;
    w.last_byte = 1'b1;
    w.no_data   = 1'b0;
    send_word(w);
  endtask

  task automatic test_random_messages(int budget);
    int stop_at;
    stop_at = data_items + budget;
    while (data_items < stop_at) begin
      tx_gap_pct = pick_gap_pct();
      send_message(pick_length());
    end
  endtask

  // The receiver holds off while short messages keep coming without gaps:
  // the digest register fills and the next last word has to wait.
  task automatic test_output_holdoff();
    hold_req   = 1'b1;
    tx_gap_pct = 0;
    repeat (12) begin
      send_message($urandom_range(0, 6));
    end
  endtask

  // Both channels run flat out to the end.
  task automatic test_unthrottled_tail(int budget);
    int stop_at;
    quiet   = 1'b1;
    stop_at = data_items + budget;
    while (data_items < stop_at) begin
      send_message(pick_length());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    fail_count   = 0;
    report_count = 0;
    data_items   = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    tx_gap_pct   = 0;
    hash_restart();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_gap_pct = 25;
    test_empty_message();
    test_single_byte_extremes();
    test_abc_vector();
    test_ignored_and_trailing_finish();
    test_random_messages(900);
    test_output_holdoff();
    test_random_messages(650);
    test_unthrottled_tail(150);

    @(negedge clk);
    in_valid <= 1'b0;

    // The timeout process bounds this wait if a digest never arrives.
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d digests outstanding", $time, digest_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/sha1d_pkg.sv
rtl/sha1d_msg_sched.sv
rtl/sha1d_round_core.sv
rtl/sha1_digest_unit.sv
dv/testbench.sv
